// ===== rtl/ihre_pkg.sv =====
// Shared types, constants and helpers of the Intel HEX record encoder.
package ihre_pkg;

   localparam int RECORD_BYTES_DEF = 16;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [6:0]  CHR_COLON     = 7'h3A;
   localparam logic [6:0]  CHR_ZERO      = 7'h30;
   localparam logic [6:0]  CHR_NEWLINE   = 7'h0A;

   // Index of the last character of each part of a record.
   localparam logic [3:0] SEG_LAST = 4'd15;
   localparam logic [3:0] HDR_LAST = 4'd8;
   localparam logic [3:0] DAT_LAST = 4'd1;
   localparam logic [3:0] TRL_LAST = 4'd2;

   // One accepted byte as classified by the front end.
   typedef struct packed {
      logic       seg;      // a segment record goes first
      logic       seg_hi;   // segment 0x1000 when set, segment 0 otherwise
      logic       hdr;      // this byte opens a record
      logic       trl;      // this byte closes a record
      logic [7:0] cnt;
      logic [7:0] addr_hi;
      logic [7:0] addr_lo;
      logic [7:0] data;
      logic [7:0] csum;
   } cmd_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] res;
      if (nib < 4'd10) begin
         res = 7'h30 + {3'b000, nib};
      end else begin
         res = 7'h37 + {3'b000, nib};
      end
      return res;
   endfunction

endpackage

// ===== rtl/intel_hex_record_encoder.sv =====
// Top level of the Intel HEX record encoder.
// Each request carries one payload byte; the encoder answers with the Intel HEX
// text it causes, one ASCII character per response, and marks the last character
// of each request with rsp_tlast. A byte costs two characters, nine more when it
// opens a record, three more when it closes one, and sixteen more when a segment
// record must precede the record. The character sequencer emits one character
// per clock unless rsp_tready stalls the output; a request has 2 to 30 characters,
// about 2.75 per byte over full 16-byte records. A two-entry command queue lets
// the front end take further bytes while earlier ones are still being spelled out.
// A request that would open a block with a length of zero is taken and dropped.
module intel_hex_record_encoder import ihre_pkg::*; #(
   parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_byte [7:0], block_address [24:8], block_length [40:25], zero fill
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ascii_char [6:0], zero fill
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   logic       push, full, pop, not_empty;
   cmd_type    push_cmd, head;
   logic [6:0] ascii_char;

   ihre_front #(
      .RECORD_BYTES (RECORD_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .data_byte     (req_tdata[7:0]),
      .block_address (req_tdata[24:8]),
      .block_length  (req_tdata[40:25]),
      .push          (push),
      .push_cmd      (push_cmd),
      .queue_full    (full)
   );

   ihre_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   ihre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (not_empty),
      .cmd        (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .ascii_char (ascii_char),
      .end_of_run (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, ascii_char};

endmodule

// ===== rtl/ihre_front.sv =====
// Front end: accepts bytes, tracks block and record state, classifies each byte.
module ihre_front import ihre_pkg::*; #(
   parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  data_byte,
   input  logic [16:0] block_address,
   input  logic [15:0] block_length,
   output logic        push,
   output cmd_type     push_cmd,
   input  logic        queue_full
);

   localparam int CW = $clog2(RECORD_BYTES + 1);
   localparam logic [CW-1:0] REC_MAX   = CW'(RECORD_BYTES);
   localparam logic [16:0]   ADDR_STEP = 17'(RECORD_BYTES);

   logic          seg_flag_ff, seg_flag_in;
   logic [16:0]   rec_addr_ff, rec_addr_in;
   logic [15:0]   bytes_left_ff, bytes_left_in;
   logic [CW-1:0] rec_left_ff, rec_left_in;
   logic [7:0]    sum_ff, sum_in;

   logic          accept, open_blk, drop;
   logic [16:0]   eff_addr;
   logic [15:0]   eff_left;
   logic [CW-1:0] eff_rl, cnt, rl, rl_new;
   logic [7:0]    eff_sum, sum0, sum1;
   logic          hdr, seg_hi, seg_lo, seg;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign open_blk = (bytes_left_ff == 16'd0);
   assign drop     = open_blk && (block_length == 16'd0);
   assign push     = accept && !drop;

   always_comb begin
      eff_addr = open_blk ? block_address : rec_addr_ff;
      eff_left = open_blk ? block_length : bytes_left_ff;
      eff_rl   = open_blk ? '0 : rec_left_ff;
      eff_sum  = open_blk ? 8'd0 : sum_ff;
      hdr      = (eff_rl == '0);
      seg_hi   = !seg_flag_ff && eff_addr[16];
      seg_lo   = seg_flag_ff && !eff_addr[16];
      seg      = hdr && (seg_hi || seg_lo);
      if (eff_left < 16'(RECORD_BYTES)) begin
         cnt = eff_left[CW-1:0];
      end else begin
         cnt = REC_MAX;
      end
      rl     = hdr ? cnt : eff_rl;
      sum0   = hdr ? (8'(cnt) + eff_addr[15:8] + eff_addr[7:0]) : eff_sum;
      sum1   = sum0 + data_byte;
      rl_new = rl - CW'(1);

      push_cmd.seg     = seg;
      push_cmd.seg_hi  = seg_hi;
      push_cmd.hdr     = hdr;
      push_cmd.trl     = (rl_new == '0);
      push_cmd.cnt     = 8'(cnt);
      push_cmd.addr_hi = eff_addr[15:8];
      push_cmd.addr_lo = eff_addr[7:0];
      push_cmd.data    = data_byte;
      push_cmd.csum    = 8'd0 - sum1;

      seg_flag_in   = seg ? !seg_flag_ff : seg_flag_ff;
      rec_addr_in   = push_cmd.trl ? (eff_addr + ADDR_STEP) : eff_addr;
      bytes_left_in = eff_left - 16'd1;
      rec_left_in   = rl_new;
      sum_in        = push_cmd.trl ? 8'd0 : sum1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_flag_ff   <= 1'b0;
         rec_addr_ff   <= '0;
         bytes_left_ff <= '0;
         rec_left_ff   <= '0;
         sum_ff        <= '0;
      end else if (push) begin
         seg_flag_ff   <= seg_flag_in;
         rec_addr_ff   <= rec_addr_in;
         bytes_left_ff <= bytes_left_in;
         rec_left_ff   <= rec_left_in;
         sum_ff        <= sum_in;
      end
   end

endmodule

// ===== rtl/ihre_queue.sv =====
// Short command queue between the front end and the character sequencer.
module ihre_queue import ihre_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]   count_ff;

   assign full      = (count_ff == NW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + NW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - NW'(1);
         end
      end
   end

endmodule

// ===== rtl/ihre_back.sv =====
// Back end: walks each queued command and emits its characters, one per cycle unless the output stalls.
module ihre_back import ihre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [6:0] ascii_char,
   output logic       end_of_run
);

   typedef enum logic [2:0] {
      PH_NEW,
      PH_SEG,
      PH_HDR,
      PH_DAT,
      PH_TRL
   } phase_type;

   phase_type  phase_ff, phase_in, eff_phase, after_phase;
   logic [3:0] idx_ff, idx_in, last_idx;
   logic       valid_ff, valid_in, last_ff, last_in;
   logic [6:0] char_ff, char_in;
   logic       load, done;

   function automatic logic [6:0] seg_char(input logic [3:0] i, input logic hi);
      logic [6:0] c;
      case (i)
         4'd0:    c = CHR_COLON;
         4'd2:    c = 7'h32;
         4'd8:    c = 7'h32;
         4'd9:    c = hi ? 7'h31 : CHR_ZERO;
         4'd13:   c = hi ? 7'h45 : 7'h46;
         4'd14:   c = 7'h43;
         4'd15:   c = CHR_NEWLINE;
         default: c = CHR_ZERO;
      endcase
      return c;
   endfunction

   assign load = cmd_valid && (!valid_ff || out_ready);

   always_comb begin
      if (phase_ff == PH_NEW) begin
         if (cmd.seg) begin
            eff_phase = PH_SEG;
         end else if (cmd.hdr) begin
            eff_phase = PH_HDR;
         end else begin
            eff_phase = PH_DAT;
         end
      end else begin
         eff_phase = phase_ff;
      end

      case (eff_phase)
         PH_SEG: begin
            last_idx    = SEG_LAST;
            after_phase = PH_HDR;
            char_in     = seg_char(idx_ff, cmd.seg_hi);
         end
         PH_HDR: begin
            last_idx    = HDR_LAST;
            after_phase = PH_DAT;
            case (idx_ff)
               4'd0:    char_in = CHR_COLON;
               4'd1:    char_in = hex_char(cmd.cnt[7:4]);
               4'd2:    char_in = hex_char(cmd.cnt[3:0]);
               4'd3:    char_in = hex_char(cmd.addr_hi[7:4]);
               4'd4:    char_in = hex_char(cmd.addr_hi[3:0]);
               4'd5:    char_in = hex_char(cmd.addr_lo[7:4]);
               4'd6:    char_in = hex_char(cmd.addr_lo[3:0]);
               default: char_in = CHR_ZERO;
            endcase
         end
         PH_DAT: begin
            last_idx    = DAT_LAST;
            after_phase = cmd.trl ? PH_TRL : PH_NEW;
            char_in     = (idx_ff == 4'd0) ? hex_char(cmd.data[7:4]) : hex_char(cmd.data[3:0]);
         end
         PH_TRL: begin
            last_idx    = TRL_LAST;
            after_phase = PH_NEW;
            case (idx_ff)
               4'd0:    char_in = hex_char(cmd.csum[7:4]);
               4'd1:    char_in = hex_char(cmd.csum[3:0]);
               default: char_in = CHR_NEWLINE;
            endcase
         end
         default: begin
            last_idx    = 4'd0;
            after_phase = PH_NEW;
            char_in     = CHR_ZERO;
         end
      endcase

      done = (idx_ff == last_idx) && (after_phase == PH_NEW);
      pop  = load && done;

      phase_in = phase_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = done;
         if (idx_ff == last_idx) begin
            phase_in = after_phase;
            idx_in   = 4'd0;
         end else begin
            phase_in = eff_phase;
            idx_in   = idx_ff + 4'd1;
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NEW;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
      if (load) begin
         char_ff <= char_in;
      end
   end

   assign out_valid  = valid_ff;
   assign ascii_char = char_ff;
   assign end_of_run = last_ff;

endmodule
